// ===== design/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Pose fall detector package
// Shared command, status and constant definitions.
// ----------------------------------------------------------------------------
package pfd_pkg;

    typedef enum logic [1:0] {
        DIV_SPEED,
        DIV_RATIO,
        DIV_DSCORE,
        DIV_DROP
    } div_sel_t;

    typedef enum logic [1:0] {
        FIN_SKIP,
        FIN_CAL,
        FIN_CALC
    } fin_kind_t;

    typedef struct packed {
        logic      load;
        logic      prep;
        logic      div_start;
        div_sel_t  div_sel;
        logic      finish;
        fin_kind_t fin_kind;
    } pfd_cmd_t;

    typedef struct packed {
        logic vis_ok;
        logic calibrated;
        logic div_done;
    } pfd_status_t;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [2:0] CFG_MIN_VIS    = 3'd0;
    localparam logic [2:0] CFG_DROP_RATIO = 3'd1;
    localparam logic [2:0] CFG_LOW_HIP    = 3'd2;
    localparam logic [2:0] CFG_DESCENT    = 3'd3;
    localparam logic [2:0] CFG_CONFIRM    = 3'd4;

endpackage

// ===== design/pose_fall_detector_core.sv =====
// ----------------------------------------------------------------------------
// Pose fall detector core
// Takes one pose frame per item and returns one fall status item per frame.
//
// The s_ channel carries the five landmark heights, their visibilities and
// the frame timestamp; the m_ channel returns one result item per frame.
// The user must write thresholds on the cfg_ port only while the block is
// idle; the block itself does not enforce this. A frame that is skipped or
// used for calibration passes from capture through the check and output
// states to the result. A tracked frame runs four divisions in turn on one
// shared radix-2 divider: a 26-step speed division and three 16-step
// saturating Q0.16 divisions; a Q0.16 division that saturates at once skips
// its steps. The next frame is accepted in the same cycle as the result
// appears, not before: no new frame is taken while one is in progress.
// Reset restores the default thresholds and clears calibration, the low
// timer, the descent flag and the latched alert.
// The result sits in an output register, so when the receiver stalls the
// block still accepts and processes the next frame, and waits only when
// that frame's result is ready while the previous one is still held.
// ----------------------------------------------------------------------------
module pose_fall_detector_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [25:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_nose_y,
    input  logic [15:0] s_left_hip_y,
    input  logic [15:0] s_right_hip_y,
    input  logic [15:0] s_left_ankle_y,
    input  logic [15:0] s_right_ankle_y,
    input  logic [15:0] s_nose_vis,
    input  logic [15:0] s_left_hip_vis,
    input  logic [15:0] s_right_hip_vis,
    input  logic [15:0] s_left_ankle_vis,
    input  logic [15:0] s_right_ankle_vis,
    input  logic [31:0] s_frame_time_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_skipped,
    output logic        m_lying_low,
    output logic [9:0]  m_confidence_tenths,
    output logic        m_alert_now,
    output logic [31:0] m_event_time_ms,
    output logic [9:0]  m_event_conf_tenths
);
    import pfd_pkg::*;

    pfd_cmd_t    cmd;
    pfd_status_t status;

    pfd_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pfd_datapath u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_nose_y            (s_nose_y),
        .s_left_hip_y        (s_left_hip_y),
        .s_right_hip_y       (s_right_hip_y),
        .s_left_ankle_y      (s_left_ankle_y),
        .s_right_ankle_y     (s_right_ankle_y),
        .s_nose_vis          (s_nose_vis),
        .s_left_hip_vis      (s_left_hip_vis),
        .s_right_hip_vis     (s_right_hip_vis),
        .s_left_ankle_vis    (s_left_ankle_vis),
        .s_right_ankle_vis   (s_right_ankle_vis),
        .s_frame_time_ms     (s_frame_time_ms),
        .cmd                 (cmd),
        .status              (status),
        .m_skipped           (m_skipped),
        .m_lying_low         (m_lying_low),
        .m_confidence_tenths (m_confidence_tenths),
        .m_alert_now         (m_alert_now),
        .m_event_time_ms     (m_event_time_ms),
        .m_event_conf_tenths (m_event_conf_tenths)
    );

endmodule

// ===== design/pfd_controller.sv =====
// ----------------------------------------------------------------------------
// Pose fall detector controller
// Sequences capture, the four divisions and result delivery.
// ----------------------------------------------------------------------------
module pfd_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  pfd_pkg::pfd_status_t status,
    output pfd_pkg::pfd_cmd_t    cmd
);
    import pfd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_START,
        S_WAIT,
        S_OUT
    } state_t;

    state_t    state_reg;
    div_sel_t  sel_reg;
    fin_kind_t kind_reg;
    logic      m_valid_reg;

    always_comb begin
        cmd           = '0;
        cmd.div_sel   = sel_reg;
        cmd.fin_kind  = kind_reg;
        case (state_reg)
            S_IDLE:  cmd.load      = s_valid;
            S_CHECK: cmd.prep      = 1'b1;
            S_START: cmd.div_start = 1'b1;
            S_OUT:   cmd.finish    = !m_valid_reg || m_ready;
            default: cmd           = '0;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sel_reg     <= DIV_SPEED;
            kind_reg    <= FIN_SKIP;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (!status.vis_ok) begin
                        kind_reg  <= FIN_SKIP;
                        state_reg <= S_OUT;
                    end else if (!status.calibrated) begin
                        kind_reg  <= FIN_CAL;
                        state_reg <= S_OUT;
                    end else begin
                        sel_reg   <= DIV_SPEED;
                        state_reg <= S_START;
                    end
                end
                S_START: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (status.div_done) begin
                        case (sel_reg)
                            DIV_SPEED: begin
                                sel_reg   <= DIV_RATIO;
                                state_reg <= S_START;
                            end
                            DIV_RATIO: begin
                                sel_reg   <= DIV_DSCORE;
                                state_reg <= S_START;
                            end
                            DIV_DSCORE: begin
                                sel_reg   <= DIV_DROP;
                                state_reg <= S_START;
                            end
                            default: begin
                                kind_reg  <= FIN_CALC;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (cmd.finish) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/pfd_datapath.sv =====
// ----------------------------------------------------------------------------
// Pose fall detector datapath
// Frame capture, shared radix-2 divider, tracking state and result registers.
// ----------------------------------------------------------------------------
module pfd_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [25:0]          cfg_wdata,
    input  logic [15:0]          s_nose_y,
    input  logic [15:0]          s_left_hip_y,
    input  logic [15:0]          s_right_hip_y,
    input  logic [15:0]          s_left_ankle_y,
    input  logic [15:0]          s_right_ankle_y,
    input  logic [15:0]          s_nose_vis,
    input  logic [15:0]          s_left_hip_vis,
    input  logic [15:0]          s_right_hip_vis,
    input  logic [15:0]          s_left_ankle_vis,
    input  logic [15:0]          s_right_ankle_vis,
    input  logic [31:0]          s_frame_time_ms,
    input  pfd_pkg::pfd_cmd_t    cmd,
    output pfd_pkg::pfd_status_t status,
    output logic                 m_skipped,
    output logic                 m_lying_low,
    output logic [9:0]           m_confidence_tenths,
    output logic                 m_alert_now,
    output logic [31:0]          m_event_time_ms,
    output logic [9:0]           m_event_conf_tenths
);
    import pfd_pkg::*;

    logic [15:0] min_vis_reg, drop_ratio_reg, low_hip_reg;
    logic [25:0] descent_reg;
    logic [19:0] confirm_reg;

    logic        vis_ok_reg;
    logic [15:0] nose_reg;
    logic [16:0] hip_sum_reg, ankle_sum_reg;
    logic [31:0] time_reg;
    logic [15:0] height_reg;
    logic [31:0] dt_reg;

    logic        calibrated_reg;
    logic [15:0] standing_reg, last_height_reg;
    logic [31:0] last_time_reg;
    logic        armed_reg;
    logic [31:0] low_start_reg;
    logic        rapid_reg;
    logic        alert_latched_reg;

    logic [25:0] speed_reg;
    logic [16:0] ratio_reg, dscore_reg, drop_reg;

    div_sel_t    dsel_reg;
    logic        busy_reg, done_reg, int_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg, den_reg;
    logic [25:0] q_reg;

    logic [16:0] nose2, abs_diff;
    logic [15:0] height_w;
    logic [31:0] div_num, div_den;
    logic        div_int, div_sat;
    logic [15:0] fall_w;
    logic [16:0] drop_num, drop_den;
    logic [32:0] r2;
    logic        ge;
    logic [31:0] rem_next;
    logic [25:0] q_next;
    logic        last_step;

    logic        lying_low_w, armed_next, rapid_next, alert_w;
    logic [31:0] start_next;
    logic [32:0] since_w, dur_w;
    logic [26:0] conf_sum;
    logic [9:0]  conf_w;

    assign nose2    = {nose_reg, 1'b0};
    assign abs_diff = (ankle_sum_reg >= nose2) ? ankle_sum_reg - nose2 : nose2 - ankle_sum_reg;
    assign height_w = abs_diff[16:1];

    assign fall_w   = last_height_reg - height_reg;
    assign drop_num = (ratio_reg < ONE_Q16) ? ONE_Q16 - ratio_reg : 17'd0;
    assign drop_den = ONE_Q16 - {1'b0, drop_ratio_reg};

    always_comb begin
        div_int = 1'b0;
        case (cmd.div_sel)
            DIV_SPEED: begin
                div_num = (last_height_reg > height_reg) ?
                          ({16'd0, fall_w} * 32'd1000) : 32'd0;
                div_den = dt_reg;
                div_int = 1'b1;
            end
            DIV_RATIO: begin
                div_num = {16'd0, height_reg};
                div_den = {16'd0, standing_reg};
            end
            DIV_DSCORE: begin
                div_num = {6'd0, speed_reg};
                div_den = {6'd0, descent_reg};
            end
            default: begin
                div_num = {15'd0, drop_num};
                div_den = {15'd0, drop_den};
            end
        endcase
    end

    assign div_sat   = !div_int && ((div_den == 32'd0) || (div_num >= div_den));
    assign r2        = {rem_reg, q_reg[25]};
    assign ge        = (r2 >= {1'b0, den_reg});
    assign rem_next  = ge ? 32'(r2 - {1'b0, den_reg}) : r2[31:0];
    assign q_next    = {q_reg[24:0], ge};
    assign last_step = int_reg ? (cnt_reg == 5'd25) : (cnt_reg == 5'd15);

    assign lying_low_w = (ratio_reg <= {1'b0, drop_ratio_reg}) &&
                         (hip_sum_reg >= {low_hip_reg, 1'b0});
    assign rapid_next  = rapid_reg || (speed_reg >= descent_reg);
    assign since_w     = {1'b0, time_reg} - {1'b0, low_start_reg};

    always_comb begin
        armed_next = armed_reg;
        start_next = low_start_reg;
        if (lying_low_w) begin
            if (!armed_reg) begin
                armed_next = 1'b1;
                start_next = time_reg;
            end
        end else if (armed_reg && ($signed(since_w) < $signed({13'd0, confirm_reg}))) begin
            armed_next = 1'b0;
        end
    end

    assign dur_w    = armed_next ? ({1'b0, time_reg} - {1'b0, start_next}) : 33'd0;
    assign alert_w  = lying_low_w && rapid_next && !alert_latched_reg &&
                      ($signed(dur_w) >= $signed({13'd0, confirm_reg}));
    assign conf_sum = ({10'd0, dscore_reg} * 27'd450) + ({10'd0, drop_reg} * 27'd350) +
                      (lying_low_w ? 27'd13107200 : 27'd0) + 27'd32768;
    assign conf_w   = conf_sum[25:16];

    assign status.vis_ok     = vis_ok_reg;
    assign status.calibrated = calibrated_reg;
    assign status.div_done   = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_vis_reg    <= 16'd32768;
            drop_ratio_reg <= 16'd32768;
            low_hip_reg    <= 16'd39322;
            descent_reg    <= 26'd65536;
            confirm_reg    <= 20'd2000;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_VIS:    min_vis_reg    <= cfg_wdata[15:0];
                CFG_DROP_RATIO: drop_ratio_reg <= cfg_wdata[15:0];
                CFG_LOW_HIP:    low_hip_reg    <= cfg_wdata[15:0];
                CFG_DESCENT:    descent_reg    <= cfg_wdata;
                CFG_CONFIRM:    confirm_reg    <= cfg_wdata[19:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            vis_ok_reg    <= (s_nose_vis >= min_vis_reg) && (s_left_hip_vis >= min_vis_reg) &&
                             (s_right_hip_vis >= min_vis_reg) &&
                             (s_left_ankle_vis >= min_vis_reg) &&
                             (s_right_ankle_vis >= min_vis_reg);
            nose_reg      <= s_nose_y;
            hip_sum_reg   <= {1'b0, s_left_hip_y} + {1'b0, s_right_hip_y};
            ankle_sum_reg <= {1'b0, s_left_ankle_y} + {1'b0, s_right_ankle_y};
            time_reg      <= s_frame_time_ms;
        end
        if (cmd.prep) begin
            height_reg <= height_w;
            dt_reg     <= (time_reg > last_time_reg) ? time_reg - last_time_reg : 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.div_start) begin
                dsel_reg <= cmd.div_sel;
                int_reg  <= div_int;
                den_reg  <= div_den;
                cnt_reg  <= 5'd0;
                rem_reg  <= div_int ? 32'd0 : div_num;
                q_reg    <= div_int ? div_num[25:0] : 26'd0;
                if (div_sat) begin
                    done_reg <= 1'b1;
                    case (cmd.div_sel)
                        DIV_RATIO:  ratio_reg  <= ONE_Q16;
                        DIV_DSCORE: dscore_reg <= ONE_Q16;
                        default:    drop_reg   <= ONE_Q16;
                    endcase
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    case (dsel_reg)
                        DIV_SPEED:  speed_reg  <= q_next;
                        DIV_RATIO:  ratio_reg  <= {1'b0, q_next[15:0]};
                        DIV_DSCORE: dscore_reg <= {1'b0, q_next[15:0]};
                        default:    drop_reg   <= {1'b0, q_next[15:0]};
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calibrated_reg    <= 1'b0;
            standing_reg      <= 16'd0;
            last_height_reg   <= 16'd0;
            last_time_reg     <= 32'd0;
            armed_reg         <= 1'b0;
            low_start_reg     <= 32'd0;
            rapid_reg         <= 1'b0;
            alert_latched_reg <= 1'b0;
        end else if (cmd.finish) begin
            case (cmd.fin_kind)
                FIN_CAL: begin
                    calibrated_reg  <= 1'b1;
                    standing_reg    <= (height_reg == 16'd0) ? 16'd1 : height_reg;
                    last_height_reg <= (height_reg == 16'd0) ? 16'd1 : height_reg;
                    last_time_reg   <= time_reg;
                end
                FIN_CALC: begin
                    last_height_reg   <= height_reg;
                    last_time_reg     <= time_reg;
                    armed_reg         <= armed_next;
                    low_start_reg     <= start_next;
                    rapid_reg         <= rapid_next;
                    alert_latched_reg <= alert_latched_reg || alert_w;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (cmd.fin_kind == FIN_CALC) begin
                m_skipped           <= 1'b0;
                m_lying_low         <= lying_low_w;
                m_confidence_tenths <= conf_w;
                m_alert_now         <= alert_w;
                m_event_time_ms     <= alert_w ? time_reg : 32'd0;
                m_event_conf_tenths <= alert_w ? ((conf_w > 10'd990) ? 10'd990 : conf_w) : 10'd0;
            end else begin
                m_skipped           <= 1'b1;
                m_lying_low         <= 1'b0;
                m_confidence_tenths <= 10'd0;
                m_alert_now         <= 1'b0;
                m_event_time_ms     <= 32'd0;
                m_event_conf_tenths <= 10'd0;
            end
        end
    end

endmodule
